>>> hw/rtl/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// mp2d_pkg: shared constants and types of the int8 max pooling stream unit
// Holds store geometry, field widths, register indexes and the tap list type.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  localparam int MAX_IN_WIDTH  = 256;
  localparam int MAX_IN_HEIGHT = 256;
  localparam int MAX_KERNEL    = 8;
  localparam int MAX_OUT       = 16;

  // accumulator store: one ring row per kernel row, padded width columns
  localparam int RING_ROWS   = MAX_KERNEL;
  localparam int STORE_COLS  = MAX_IN_WIDTH + 8;
  localparam int STORE_DEPTH = RING_ROWS * STORE_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int RING_W      = $clog2(RING_ROWS);
  localparam int TAP_W       = $clog2(MAX_KERNEL);

  localparam int PIX_W     = 8;
  localparam int POS_W     = 9;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 4;
  localparam int CNT_W     = $clog2(MAX_OUT + 1);

  typedef logic signed [PIX_W-1:0] pixel_t;
  typedef logic [POS_W-1:0]        pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_HEIGHT = 4'd0,
    REG_IN_WIDTH  = 4'd1,
    REG_KERNEL_H  = 4'd2,
    REG_KERNEL_W  = 4'd3,
    REG_STRIDE_H  = 4'd4,
    REG_STRIDE_W  = 4'd5,
    REG_PAD_H     = 4'd6,
    REG_PAD_W     = 4'd7
  } cfg_reg_t;

  // windows along one dimension that hold the current pixel, one per tap offset
  typedef struct packed {
    logic [MAX_KERNEL-1:0]            vld;
    logic [MAX_KERNEL-1:0]            first;
    logic [MAX_KERNEL-1:0]            last;
    logic [MAX_KERNEL-1:0][POS_W-1:0] idx;
  } tap_list_t;

endpackage

>>> hw/rtl/mp2d_pixel_if.sv
// ----------------------------------------------------------------------------
// mp2d_pixel_if: input pixel channel
// One beat carries one pixel and the plane start mark.
// ----------------------------------------------------------------------------
interface mp2d_pixel_if;
  logic             valid;
  logic             ready;
  mp2d_pkg::pixel_t pixel_value;
  logic             plane_start;

  modport source (output valid, output pixel_value, output plane_start, input ready);
  modport sink   (input valid, input pixel_value, input plane_start, output ready);
endinterface

>>> hw/rtl/mp2d_result_if.sv
// ----------------------------------------------------------------------------
// mp2d_result_if: pooled result channel
// One beat carries one window maximum with its output row and column.
// ----------------------------------------------------------------------------
interface mp2d_result_if;
  logic             valid;
  logic             ready;
  mp2d_pkg::pixel_t pooled_value;
  mp2d_pkg::pos_t   out_row;
  mp2d_pkg::pos_t   out_col;
  logic             last_result;

  modport source (output valid, output pooled_value, output out_row, output out_col,
                  output last_result, input ready);
  modport sink   (input valid, input pooled_value, input out_row, input out_col,
                  input last_result, output ready);
endinterface

>>> hw/rtl/maxpool2d_int8_stream_unit.sv
// ----------------------------------------------------------------------------
// maxpool2d_int8_stream_unit: streaming 2-D max pooling of int8 pixels
// Window maxima live in one synchronous RAM and are updated read-modify-write.
// ----------------------------------------------------------------------------
// Usage:
//   pixel_in carries pixels of a plane in raster order; plane_start marks the
//   first pixel of a plane. pool_out carries one beat per finished window
//   (maximum, output row, output column); last_result flags the final beat
//   caused by a pixel. Registers are written through cfg_we/cfg_index/cfg_wdata
//   while the unit is idle.
//   Per pixel the unit issues one read-modify-write for each of the R*C window
//   pairs that hold it, where R and C are the numbers of row and column windows.
//   The accumulator RAM does one read-modify-write per cycle unless pool_out
//   stalls a result. A result passes the window sequencer, the RAM stage and
//   the result register. After a register write the unit rebuilds its window
//   phase counters by restoring division before it takes the next pixel.
//   Reset clears the position to row 0, column 0 and loads default registers;
//   the RAM is not cleared, as each window loads on its first real tap.
//   When pool_out stalls, the result register holds and the RAM pipeline
//   stops; pixel_in is taken again once the current pixel's windows are issued.
// ----------------------------------------------------------------------------
module maxpool2d_int8_stream_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mp2d_pkg::CFG_W-1:0]       cfg_wdata,
  mp2d_pixel_if.sink                       pixel_in,
  mp2d_result_if.source                    pool_out
);

  localparam int KW = mp2d_pkg::MAX_KERNEL;
  localparam int PW = mp2d_pkg::POS_W;
  localparam int TW = mp2d_pkg::TAP_W;
  localparam int AW = mp2d_pkg::ADDR_W;
  localparam int CW = mp2d_pkg::CNT_W;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic [PW-1:0] clamp_size(input logic [PW-1:0] v, input int hi);
    if (v == '0) return PW'(1);
    if (v > PW'(hi)) return PW'(hi);
    return v;
  endfunction

  function automatic logic [3:0] clamp_kern(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v > 4'(mp2d_pkg::MAX_KERNEL)) return 4'(mp2d_pkg::MAX_KERNEL);
    return v;
  endfunction

  // quotient and remainder of pad / stride for a position of zero
  function automatic logic [PW-1:0] init_q(input logic [1:0] p, input logic [3:0] s);
    case (s)
      4'd1:    return PW'(p);
      4'd2:    return PW'(p[1]);
      4'd3:    return PW'(p == 2'd3);
      default: return '0;
    endcase
  endfunction

  function automatic logic [3:0] init_r(input logic [1:0] p, input logic [3:0] s);
    case (s)
      4'd1:    return 4'd0;
      4'd2:    return 4'(p[0]);
      4'd3:    return (p == 2'd3) ? 4'd0 : 4'(p);
      default: return 4'(p);
    endcase
  endfunction

  // windows holding position pos: offset m is window q-m at tap r+m*s
  function automatic mp2d_pkg::tap_list_t build_list(
    input logic [PW-1:0] pos, input logic [PW-1:0] size, input logic [3:0] k,
    input logic [3:0] s, input logic [1:0] p, input logic [PW-1:0] q,
    input logic [3:0] r);
    mp2d_pkg::tap_list_t tl;
    logic [7:0]          kk;
    logic signed [11:0]  tt;
    logic signed [11:0]  lim;
    lim = 12'(size) + 12'({p, 1'b0}) - 12'(k);
    for (int m = 0; m < KW; m++) begin
      kk = 8'(r) + 8'(m) * 8'(s);
      tt = 12'(pos) + 12'(p) - 12'(kk);
      tl.vld[m]   = (kk < 8'(k)) && !tt[11] && (tt <= lim);
      tl.idx[m]   = q - PW'(m);
      tl.first[m] = (kk == 8'd0) || (pos == '0);
      tl.last[m]  = (kk == 8'(k) - 8'd1) || (10'(pos) + 10'd1 >= 10'(size));
    end
    return tl;
  endfunction

  function automatic logic [TW-1:0] top_bit(input logic [KW-1:0] v);
    logic [TW-1:0] res;
    res = '0;
    for (int i = 0; i < KW; i++) begin
      if (v[i]) res = TW'(i);
    end
    return res;
  endfunction

  function automatic logic [TW-1:0] low_bit(input logic [KW-1:0] v);
    logic [TW-1:0] res;
    res = '0;
    for (int i = KW - 1; i >= 0; i--) begin
      if (v[i]) res = TW'(i);
    end
    return res;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [PW-1:0] orow,
                                              input logic [PW-1:0] ocol);
    return AW'(orow[mp2d_pkg::RING_W-1:0]) * AW'(mp2d_pkg::STORE_COLS) + AW'(ocol);
  endfunction

  function automatic logic [3:0] phase_inc(input logic [3:0] r, input logic [3:0] s);
    return (r + 4'd1 == s) ? 4'd0 : r + 4'd1;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [8:0] cfg_in_height, cfg_in_width;
  logic [3:0] cfg_kernel_h, cfg_kernel_w, cfg_stride_h, cfg_stride_w;
  logic [1:0] cfg_pad_h, cfg_pad_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_in_height <= 9'd1;
      cfg_in_width  <= 9'd1;
      cfg_kernel_h  <= 4'd1;
      cfg_kernel_w  <= 4'd1;
      cfg_stride_h  <= 4'd1;
      cfg_stride_w  <= 4'd1;
      cfg_pad_h     <= 2'd0;
      cfg_pad_w     <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mp2d_pkg::REG_IN_HEIGHT: cfg_in_height <= cfg_wdata;
        mp2d_pkg::REG_IN_WIDTH:  cfg_in_width  <= cfg_wdata;
        mp2d_pkg::REG_KERNEL_H:  cfg_kernel_h  <= cfg_wdata[3:0];
        mp2d_pkg::REG_KERNEL_W:  cfg_kernel_w  <= cfg_wdata[3:0];
        mp2d_pkg::REG_STRIDE_H:  cfg_stride_h  <= cfg_wdata[3:0];
        mp2d_pkg::REG_STRIDE_W:  cfg_stride_w  <= cfg_wdata[3:0];
        mp2d_pkg::REG_PAD_H:     cfg_pad_h     <= cfg_wdata[1:0];
        mp2d_pkg::REG_PAD_W:     cfg_pad_w     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [PW-1:0] ih, iw;
  logic [3:0]    kh, kw, sh, sw;

  assign ih = clamp_size(cfg_in_height, mp2d_pkg::MAX_IN_HEIGHT);
  assign iw = clamp_size(cfg_in_width, mp2d_pkg::MAX_IN_WIDTH);
  assign kh = clamp_kern(cfg_kernel_h);
  assign kw = clamp_kern(cfg_kernel_w);
  assign sh = (cfg_stride_h == 4'd0) ? 4'd1 : cfg_stride_h;
  assign sw = (cfg_stride_w == 4'd0) ? 4'd1 : cfg_stride_w;

  // --------------------------------------------------------------------------
  // position and window phase: q = (pos+pad)/stride, r = (pos+pad)%stride
  // --------------------------------------------------------------------------
  logic [PW-1:0] rpos, cpos, rq, cq;
  logic [3:0]    rr, cr;

  // phase rebuild after a register write: restoring division, one bit a cycle
  logic          div_run;
  logic [3:0]    div_cnt;
  logic [4:0]    div_rrem, div_crem;
  logic [PW-1:0] div_rquo, div_cquo;
  logic [PW-1:0] reff, ceff, rnum, cnum;
  logic [3:0]    div_bit;
  logic [4:0]    rsh, csh, rrem_next, crem_next;
  logic [PW-1:0] rquo_next, cquo_next;

  assign reff    = (rpos >= ih) ? '0 : rpos;
  assign ceff    = (cpos >= iw) ? '0 : cpos;
  assign rnum    = reff + PW'(cfg_pad_h);
  assign cnum    = ceff + PW'(cfg_pad_w);
  assign div_bit = 4'(PW - 1) - div_cnt;

  always_comb begin
    rsh       = {div_rrem[3:0], rnum[div_bit]};
    csh       = {div_crem[3:0], cnum[div_bit]};
    rquo_next = div_rquo;
    cquo_next = div_cquo;
    rrem_next = rsh;
    crem_next = csh;
    if (rsh >= 5'(sh)) begin
      rrem_next          = rsh - 5'(sh);
      rquo_next[div_bit] = 1'b1;
    end
    if (csh >= 5'(sw)) begin
      crem_next          = csh - 5'(sw);
      cquo_next[div_bit] = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // pixel accept and window lists
  // --------------------------------------------------------------------------
  logic busy;
  logic in_fire;

  assign pixel_in.ready = !busy && !div_run;
  assign in_fire        = pixel_in.valid && pixel_in.ready;

  logic [PW-1:0]       acc_r, acc_c, acc_rq, acc_cq;
  logic [3:0]          acc_rr, acc_cr;
  mp2d_pkg::tap_list_t rows_c, cols_c;

  always_comb begin
    acc_r  = pixel_in.plane_start ? '0 : rpos;
    acc_c  = pixel_in.plane_start ? '0 : cpos;
    acc_rq = pixel_in.plane_start ? init_q(cfg_pad_h, sh) : rq;
    acc_rr = pixel_in.plane_start ? init_r(cfg_pad_h, sh) : rr;
    acc_cq = pixel_in.plane_start ? init_q(cfg_pad_w, sw) : cq;
    acc_cr = pixel_in.plane_start ? init_r(cfg_pad_w, sw) : cr;
    rows_c = build_list(acc_r, ih, kh, sh, cfg_pad_h, acc_rq, acc_rr);
    cols_c = build_list(acc_c, iw, kw, sw, cfg_pad_w, acc_cq, acc_cr);
  end

  // advance position after the accepted pixel; rebuild the phase after a register write
  always_ff @(posedge clk) begin
    if (rst) begin
      rpos     <= '0;
      cpos     <= '0;
      rq       <= '0;
      rr       <= '0;
      cq       <= '0;
      cr       <= '0;
      div_run  <= 1'b0;
      div_cnt  <= '0;
      div_rrem <= '0;
      div_crem <= '0;
      div_rquo <= '0;
      div_cquo <= '0;
    end else if (cfg_we) begin
      div_run  <= 1'b1;
      div_cnt  <= '0;
      div_rrem <= '0;
      div_crem <= '0;
      div_rquo <= '0;
      div_cquo <= '0;
    end else if (div_run) begin
      div_cnt  <= div_cnt + 4'd1;
      div_rrem <= rrem_next;
      div_crem <= crem_next;
      div_rquo <= rquo_next;
      div_cquo <= cquo_next;
      if (div_cnt == 4'(PW - 1)) begin
        div_run <= 1'b0;
        rpos    <= reff;
        cpos    <= ceff;
        rq      <= rquo_next;
        rr      <= rrem_next[3:0];
        cq      <= cquo_next;
        cr      <= crem_next[3:0];
      end
    end else if (in_fire) begin
      if (acc_c + PW'(1) >= iw) begin
        cpos <= '0;
        cq   <= init_q(cfg_pad_w, sw);
        cr   <= init_r(cfg_pad_w, sw);
        if (acc_r + PW'(1) >= ih) begin
          rpos <= '0;
          rq   <= init_q(cfg_pad_h, sh);
          rr   <= init_r(cfg_pad_h, sh);
        end else begin
          rpos <= acc_r + PW'(1);
          rq   <= (phase_inc(acc_rr, sh) == 4'd0) ? acc_rq + PW'(1) : acc_rq;
          rr   <= phase_inc(acc_rr, sh);
        end
      end else begin
        cpos <= acc_c + PW'(1);
        cq   <= (phase_inc(acc_cr, sw) == 4'd0) ? acc_cq + PW'(1) : acc_cq;
        cr   <= phase_inc(acc_cr, sw);
        rpos <= acc_r;
        rq   <= acc_rq;
        rr   <= acc_rr;
      end
    end
  end

  // --------------------------------------------------------------------------
  // window pair sequencer: rows ascending, columns ascending
  // --------------------------------------------------------------------------
  mp2d_pkg::tap_list_t rows, cols;
  mp2d_pkg::pixel_t    pix;
  logic [TW-1:0]       ri, ci, row_fin, col_fin;
  logic [CW-1:0]       emit_cnt;

  logic                rmw_valid, rmw_fire, issue;
  logic [KW-1:0]       row_below, col_below;
  logic                emit_now, is_last;
  logic [AW-1:0]       issue_addr;

  assign issue      = busy && (!rmw_valid || rmw_fire);
  assign row_below  = rows.vld & ((KW'(1) << ri) - KW'(1));
  assign col_below  = cols.vld & ((KW'(1) << ci) - KW'(1));
  assign emit_now   = rows.last[ri] && cols.last[ci] && (emit_cnt < CW'(mp2d_pkg::MAX_OUT));
  assign is_last    = emit_now && (((ri == row_fin) && (ci == col_fin)) ||
                                   (emit_cnt == CW'(mp2d_pkg::MAX_OUT - 1)));
  assign issue_addr = slot_addr(rows.idx[ri], cols.idx[ci]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      emit_cnt <= '0;
    end else if (in_fire) begin
      busy     <= (rows_c.vld != '0) && (cols_c.vld != '0);
      rows     <= rows_c;
      cols     <= cols_c;
      pix      <= pixel_in.pixel_value;
      ri       <= top_bit(rows_c.vld);
      ci       <= top_bit(cols_c.vld);
      row_fin  <= low_bit(rows_c.vld & rows_c.last);
      col_fin  <= low_bit(cols_c.vld & cols_c.last);
      emit_cnt <= '0;
    end else if (issue) begin
      emit_cnt <= emit_cnt + CW'(emit_now);
      if (col_below != '0) begin
        ci <= top_bit(col_below);
      end else if (row_below != '0) begin
        ri <= top_bit(row_below);
        ci <= top_bit(cols.vld);
      end else begin
        busy <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // accumulator RAM, read stage and update stage with forwarding
  // --------------------------------------------------------------------------
  logic [7:0]       store [mp2d_pkg::STORE_DEPTH];
  logic [7:0]       rd_data;
  logic             fwd_hit;
  logic [7:0]       fwd_data;

  logic [AW-1:0]    rmw_addr;
  logic             rmw_load, rmw_emit, rmw_last;
  mp2d_pkg::pixel_t rmw_pix;
  logic [PW-1:0]    rmw_row, rmw_col;
  mp2d_pkg::pixel_t old_val, acc_val;

  logic             out_valid;

  assign rmw_fire = rmw_valid && (!rmw_emit || !out_valid || pool_out.ready);

  always_comb begin
    old_val = fwd_hit ? mp2d_pkg::pixel_t'(fwd_data) : mp2d_pkg::pixel_t'(rd_data);
    acc_val = (rmw_load || (rmw_pix > old_val)) ? rmw_pix : old_val;
  end

  // write back the updated maximum, read the next window's entry
  always_ff @(posedge clk) begin
    if (rmw_fire) begin
      store[rmw_addr] <= acc_val;
    end
    if (issue) begin
      rd_data  <= store[issue_addr];
      fwd_hit  <= rmw_fire && (rmw_addr == issue_addr);
      fwd_data <= acc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rmw_valid <= 1'b0;
    end else if (!rmw_valid || rmw_fire) begin
      rmw_valid <= issue;
      rmw_addr  <= issue_addr;
      rmw_load  <= rows.first[ri] && cols.first[ci];
      rmw_emit  <= emit_now;
      rmw_last  <= is_last;
      rmw_pix   <= pix;
      rmw_row   <= rows.idx[ri];
      rmw_col   <= cols.idx[ci];
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rmw_fire && rmw_emit) begin
      out_valid             <= 1'b1;
      pool_out.pooled_value <= acc_val;
      pool_out.out_row      <= rmw_row;
      pool_out.out_col      <= rmw_col;
      pool_out.last_result  <= rmw_last;
    end else if (pool_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign pool_out.valid = out_valid;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (busy || div_run) |-> !pixel_in.ready)
    else $error("pixel beat taken while windows or phase rebuild pending");

  a_emit_cap: assert property (@(posedge clk) disable iff (rst)
    emit_cnt <= CW'(mp2d_pkg::MAX_OUT))
    else $error("more results than allowed for one pixel");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    rmw_valid |-> (rmw_addr < AW'(mp2d_pkg::STORE_DEPTH)))
    else $error("accumulator address beyond store");

  a_fwd_follows_write: assert property (@(posedge clk) disable iff (rst)
    (issue && rmw_fire && (rmw_addr == issue_addr)) |=> fwd_hit)
    else $error("read of entry under write not forwarded");

endmodule
